FILE: design/fms_pkg.sv
// Shared types and constants of the factorization machine scorer.
`timescale 1ns / 1ps

package fms_pkg;

   typedef struct packed {
      logic               command;
      logic [11:0]        feature_index;
      logic [3:0]         slot;
      logic signed [15:0] weight_value;
      logic signed [15:0] feature_value;
      logic               last;
      logic               normalize;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] score;
      logic               saturated;
   } rsp_payload_type;

   // Work codes handed from the front to the back.
   localparam logic [1:0] OP_WRITE     = 2'd0;
   localparam logic [1:0] OP_ELEM      = 2'd1;
   localparam logic [1:0] OP_ELEM_LAST = 2'd2;
   localparam logic [1:0] OP_FINISH    = 2'd3;

   typedef struct packed {
      logic [1:0]         op;
      logic [11:0]        feature_index;
      logic [3:0]         slot;
      logic signed [15:0] value;
      logic               normalize;
   } queue_item_type;

   localparam int QUEUE_DEPTH = 4;

   // floor(v / 6) equals (v * RECIP_SIX) >> 23 for every v below 2^20.
   localparam logic [31:0] RECIP_SIX = 32'd1398102;

endpackage

FILE: design/factorization_machine_score_core.sv
// Top level of the factorization machine second-order scorer.
`timescale 1ns / 1ps

// Scores sparse feature rows with a second-order factorization machine. Load the
// weight table with write beats (slot 0 is the linear weight, slots 1 to FACTORS the
// latent factors, feature 0 slot 0 the bias), then stream the elements of a row; the
// beat flagged last yields one result beat with the Q16.16 score, optionally through
// a sigmoid. A front stage filters and classifies request beats into a four-entry
// queue, so requests keep flowing while the back end works or a result waits. The
// back end reads the table slots one at a time from a single-port-read RAM and
// shares one 32x32 multiplier among its squaring and sigmoid steps; it pops the next
// queue item only from idle, once the element or row at hand is done.
module factorization_machine_score_core #(
   parameter int NUM_FEATURES = 4096,
   parameter int FACTORS      = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  fms_pkg::req_payload_type  req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output fms_pkg::rsp_payload_type  rsp_data,
   input  logic                     csr_write_enable,
   input  logic                     csr_write_data
);
   import fms_pkg::*;

   logic           push;
   queue_item_type push_item;
   logic           queue_full;
   logic           pop;
   queue_item_type pop_item;
   logic           queue_empty;

   fms_front #(
      .NUM_FEATURES(NUM_FEATURES),
      .FACTORS     (FACTORS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .push      (push),
      .push_item (push_item),
      .queue_full(queue_full)
   );

   fms_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_item(push_item),
      .full     (queue_full),
      .pop      (pop),
      .pop_item (pop_item),
      .empty    (queue_empty)
   );

   fms_back #(
      .NUM_FEATURES(NUM_FEATURES),
      .FACTORS     (FACTORS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_item        (pop_item),
      .queue_empty     (queue_empty),
      .pop             (pop),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data)
   );
endmodule

FILE: design/fms_ram.sv
// Generic simple dual-port RAM with a registered read.
`timescale 1ns / 1ps

module fms_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: design/fms_queue.sv
// Short work queue between the front and the back.
`timescale 1ns / 1ps

module fms_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  fms_pkg::queue_item_type push_item,
   output logic                   full,
   input  logic                   pop,
   output fms_pkg::queue_item_type pop_item,
   output logic                   empty
);
   import fms_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);

   queue_item_type  entry_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PW:0]     count_ff, count_in;

   assign full     = (count_ff == (PW+1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end
endmodule

FILE: design/fms_front.sv
// Front end: accepts request beats, drops what has no effect, classifies the rest.
`timescale 1ns / 1ps

module fms_front #(
   parameter int NUM_FEATURES = 4096,
   parameter int FACTORS      = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  fms_pkg::req_payload_type req_data,
   output logic                    push,
   output fms_pkg::queue_item_type push_item,
   input  logic                    queue_full
);
   import fms_pkg::*;

   logic           hold_valid_ff, hold_valid_in;
   queue_item_type hold_item_ff, hold_item_in;
   logic           accept;
   logic           index_ok;
   logic           slot_ok;
   logic           keep;

   assign req_stall = hold_valid_ff & queue_full;
   assign accept    = req_valid & ~req_stall;
   assign push      = hold_valid_ff & ~queue_full;
   assign push_item = hold_item_ff;

   always_comb begin
      index_ok = {20'd0, req_data.feature_index} < 32'(NUM_FEATURES);
      slot_ok  = {28'd0, req_data.slot} <= 32'(FACTORS);
      hold_item_in.feature_index = req_data.feature_index;
      hold_item_in.slot          = req_data.slot;
      hold_item_in.normalize     = req_data.normalize;
      if (req_data.command == 1'b0) begin
         keep                 = index_ok & slot_ok;
         hold_item_in.op      = OP_WRITE;
         hold_item_in.value   = req_data.weight_value;
      end else begin
         // An element with a bad index still closes the row when it is last.
         keep               = index_ok | req_data.last;
         hold_item_in.value = req_data.feature_value;
         if (!index_ok) begin
            hold_item_in.op = OP_FINISH;
         end else if (req_data.last) begin
            hold_item_in.op = OP_ELEM_LAST;
         end else begin
            hold_item_in.op = OP_ELEM;
         end
      end
      if (accept) begin
         hold_valid_in = keep;
      end else if (push) begin
         hold_valid_in = 1'b0;
      end else begin
         hold_valid_in = hold_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hold_item_ff <= hold_item_in;
      end
   end
endmodule

FILE: design/fms_back.sv
// Back end: weight table, accumulation over slots, score and sigmoid sequencer.
`timescale 1ns / 1ps

module fms_back #(
   parameter int NUM_FEATURES = 4096,
   parameter int FACTORS      = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  fms_pkg::queue_item_type pop_item,
   input  logic                    queue_empty,
   output logic                    pop,
   input  logic                    csr_write_enable,
   input  logic                    csr_write_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output fms_pkg::rsp_payload_type rsp_data
);
   import fms_pkg::*;

   localparam int ROW   = FACTORS + 1;
   localparam int DEPTH = NUM_FEATURES * ROW;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = ($clog2(FACTORS + 1) > 5) ? $clog2(FACTORS + 1) : 5;

   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_RD      = 5'd1;
   localparam logic [4:0] S_MUL     = 5'd2;
   localparam logic [4:0] S_SQ      = 5'd3;
   localparam logic [4:0] S_ACC     = 5'd4;
   localparam logic [4:0] S_BIAS_RD = 5'd5;
   localparam logic [4:0] S_BIAS    = 5'd6;
   localparam logic [4:0] S_M       = 5'd7;
   localparam logic [4:0] S_P1      = 5'd8;
   localparam logic [4:0] S_P2      = 5'd9;
   localparam logic [4:0] S_P3      = 5'd10;
   localparam logic [4:0] S_P4      = 5'd11;
   localparam logic [4:0] S_P5      = 5'd12;
   localparam logic [4:0] S_LIN     = 5'd13;
   localparam logic [4:0] S_SCORE   = 5'd14;
   localparam logic [4:0] S_SIG0    = 5'd15;
   localparam logic [4:0] S_H2      = 5'd16;
   localparam logic [4:0] S_H3      = 5'd17;
   localparam logic [4:0] S_H4      = 5'd18;
   localparam logic [4:0] S_D6A     = 5'd19;
   localparam logic [4:0] S_D6B     = 5'd20;
   localparam logic [4:0] S_E       = 5'd21;
   localparam logic [4:0] S_SQE1    = 5'd22;
   localparam logic [4:0] S_SQE2    = 5'd23;
   localparam logic [4:0] S_DIV0    = 5'd24;
   localparam logic [4:0] S_DIV     = 5'd25;
   localparam logic [4:0] S_SIGOUT  = 5'd26;
   localparam logic [4:0] S_OUT     = 5'd27;

   logic [4:0]          state_ff, state_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [AW-1:0]       base_ff, base_in;
   logic signed [15:0]  x_ff, x_in;
   logic                last_ff, last_in;
   logic                norm_ff, norm_in;
   logic signed [31:0]  p_ff, p_in;
   logic [63:0]         prod_ff;
   logic signed [47:0]  lin_ff, lin_in;
   logic signed [39:0]  s_ff [FACTORS];
   logic signed [39:0]  s_in [FACTORS];
   logic signed [55:0]  q_ff [FACTORS];
   logic signed [55:0]  q_in [FACTORS];
   logic [39:0]         m_ff, m_in;
   logic [79:0]         sq_ff, sq_in;
   logic signed [63:0]  total_ff, total_in;
   logic signed [31:0]  raw_ff, raw_in;
   logic                sat_ff, sat_in;
   logic [31:0]         res_ff, res_in;
   logic [27:0]         h_ff, h_in;
   logic [23:0]         h2_ff, h2_in;
   logic [19:0]         h3_ff, h3_in;
   logic [15:0]         h4_ff, h4_in;
   logic [16:0]         d3_ff, d3_in;
   logic [31:0]         e_ff, e_in;
   logic [32:0]         den_ff, den_in;
   logic [32:0]         rem_ff, rem_in;
   logic [16:0]         nq_ff, nq_in;
   logic                use_linear_ff, use_linear_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_payload_type     rsp_data_ff, rsp_data_in;

   logic [31:0]         mul_a, mul_b;
   logic [63:0]         mul_prod;
   logic                ram_we;
   logic [AW-1:0]       ram_wr_addr, ram_rd_addr;
   logic [15:0]         ram_rd_data;
   logic signed [15:0]  rd_word;
   logic [31:0]         write_addr, elem_base;
   logic [31:0]         p_mag;
   logic [40:0]         s_mag;
   logic signed [63:0]  shifted;
   logic [32:0]         r_mag;
   logic [32:0]         trial;
   logic [47:0]         n_full;
   logic [63:0]         sq_round;
   logic signed [39:0]  s_new;
   logic signed [55:0]  q_new;
   logic                out_free;

   fms_ram #(
      .WIDTH(16),
      .DEPTH(DEPTH)
   ) u_weight_table (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_wr_addr),
      .wr_data(pop_item.value),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   assign rd_word     = ram_rd_data;
   assign write_addr  = 32'(pop_item.feature_index) * 32'(ROW) + 32'(pop_item.slot);
   assign elem_base   = 32'(pop_item.feature_index) * 32'(ROW);
   assign ram_wr_addr = write_addr[AW-1:0];
   assign ram_rd_addr = (state_ff == S_BIAS_RD) ? '0 : base_ff + AW'(cnt_ff);
   assign mul_prod    = mul_a * mul_b;
   assign out_free    = ~rsp_valid_ff | ~rsp_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_data_ff;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      base_in       = base_ff;
      x_in          = x_ff;
      last_in       = last_ff;
      norm_in       = norm_ff;
      p_in          = p_ff;
      lin_in        = lin_ff;
      s_in          = s_ff;
      q_in          = q_ff;
      m_in          = m_ff;
      sq_in         = sq_ff;
      total_in      = total_ff;
      raw_in        = raw_ff;
      sat_in        = sat_ff;
      res_in        = res_ff;
      h_in          = h_ff;
      h2_in         = h2_ff;
      h3_in         = h3_ff;
      h4_in         = h4_ff;
      d3_in         = d3_ff;
      e_in          = e_ff;
      den_in        = den_ff;
      rem_in        = rem_ff;
      nq_in         = nq_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      use_linear_in = csr_write_enable ? csr_write_data : use_linear_ff;
      pop           = 1'b0;
      ram_we        = 1'b0;
      mul_a         = '0;
      mul_b         = '0;

      p_mag    = p_ff[31] ? 32'd0 - 32'(p_ff) : 32'(p_ff);
      s_mag    = s_ff[0][39] ? 41'd0 - 41'(s_ff[0]) : 41'(s_ff[0]);
      shifted  = total_ff >>> 9;
      r_mag    = raw_ff[31] ? 33'd0 - 33'(raw_ff) : 33'(raw_ff);
      trial    = {rem_ff[31:0], nq_ff[16]};
      n_full   = 48'h8000_0000_0000 + 48'(den_ff[32:1]);
      sq_round = prod_ff + 64'd1073741824;
      s_new    = s_ff[0] + 40'(p_ff);
      q_new    = q_ff[0] + 56'(prod_ff[63:24]);

      unique case (state_ff)
         S_IDLE: begin
            if (!queue_empty) begin
               pop     = 1'b1;
               norm_in = pop_item.normalize;
               unique case (pop_item.op)
                  OP_WRITE: begin
                     ram_we = 1'b1;
                  end
                  OP_ELEM, OP_ELEM_LAST: begin
                     base_in  = elem_base[AW-1:0];
                     x_in     = pop_item.value;
                     last_in  = (pop_item.op == OP_ELEM_LAST);
                     cnt_in   = '0;
                     state_in = S_RD;
                  end
                  OP_FINISH: begin
                     state_in = S_BIAS_RD;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_RD: begin
            state_in = S_MUL;
         end
         S_MUL: begin
            p_in     = 32'(rd_word) * 32'(x_ff);
            state_in = S_SQ;
         end
         S_SQ: begin
            if (cnt_ff == '0) begin
               lin_in   = lin_ff + 48'(p_ff);
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_RD;
            end else begin
               mul_a    = p_mag;
               mul_b    = p_mag;
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            // The sums rotate so that the factor at hand is always at the head.
            for (int i = 0; i < FACTORS - 1; i++) begin
               s_in[i] = s_ff[i+1];
               q_in[i] = q_ff[i+1];
            end
            s_in[FACTORS-1] = s_new;
            q_in[FACTORS-1] = q_new;
            if (cnt_ff == CW'(FACTORS)) begin
               state_in = last_ff ? S_BIAS_RD : S_IDLE;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_RD;
            end
         end
         S_BIAS_RD: begin
            state_in = S_BIAS;
         end
         S_BIAS: begin
            // The total is kept with one extra fraction bit, so the bias doubles.
            total_in = use_linear_ff ? (64'(rd_word) <<< 13) : '0;
            cnt_in   = '0;
            state_in = S_M;
         end
         S_M: begin
            m_in     = s_mag[39:0];
            total_in = total_ff - 64'(q_ff[0]);
            state_in = S_P1;
         end
         S_P1: begin
            mul_a    = 32'(m_ff[39:20]);
            mul_b    = 32'(m_ff[39:20]);
            state_in = S_P2;
         end
         S_P2: begin
            sq_in    = 80'(prod_ff) << 40;
            mul_a    = 32'(m_ff[39:20]);
            mul_b    = 32'(m_ff[19:0]);
            state_in = S_P3;
         end
         S_P3: begin
            sq_in    = sq_ff + (80'(prod_ff) << 21);
            mul_a    = 32'(m_ff[19:0]);
            mul_b    = 32'(m_ff[19:0]);
            state_in = S_P4;
         end
         S_P4: begin
            sq_in    = sq_ff + 80'(prod_ff);
            state_in = S_P5;
         end
         S_P5: begin
            total_in = total_ff + 64'(sq_ff[79:24]);
            for (int i = 0; i < FACTORS - 1; i++) begin
               s_in[i] = s_ff[i+1];
               q_in[i] = q_ff[i+1];
            end
            s_in[FACTORS-1] = s_ff[0];
            q_in[FACTORS-1] = q_ff[0];
            if (cnt_ff == CW'(FACTORS - 1)) begin
               state_in = S_LIN;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_M;
            end
         end
         S_LIN: begin
            if (use_linear_ff) begin
               total_in = total_ff + (64'(lin_ff) <<< 1);
            end
            state_in = S_SCORE;
         end
         S_SCORE: begin
            if ((&shifted[63:31]) || (~|shifted[63:31])) begin
               raw_in = shifted[31:0];
               sat_in = 1'b0;
            end else begin
               raw_in = shifted[63] ? 32'sh8000_0000 : 32'sh7fff_ffff;
               sat_in = 1'b1;
            end
            res_in   = raw_in;
            state_in = norm_ff ? S_SIG0 : S_OUT;
         end
         S_SIG0: begin
            // h is min(|score|, 16) / 256 in Q.31.
            h_in     = (r_mag > 33'd1048576) ? 28'd134217728 : {r_mag[20:0], 7'd0};
            state_in = S_H2;
         end
         S_H2: begin
            mul_a    = 32'(h_ff);
            mul_b    = 32'(h_ff);
            state_in = S_H3;
         end
         S_H3: begin
            h2_in    = prod_ff[54:31];
            mul_a    = prod_ff[62:31];
            mul_b    = 32'(h_ff);
            state_in = S_H4;
         end
         S_H4: begin
            h3_in    = prod_ff[50:31];
            mul_a    = prod_ff[62:31];
            mul_b    = 32'(h_ff);
            state_in = S_D6A;
         end
         S_D6A: begin
            h4_in    = prod_ff[46:31];
            mul_a    = 32'(h3_ff);
            mul_b    = RECIP_SIX;
            state_in = S_D6B;
         end
         S_D6B: begin
            d3_in    = prod_ff[39:23];
            // floor(h4 / 24) is floor(floor(h4 / 4) / 6).
            mul_a    = 32'(h4_ff[15:2]);
            mul_b    = RECIP_SIX;
            e_in     = 32'(33'd2147483648 - 33'(h_ff) + 33'(h2_ff[23:1]));
            state_in = S_E;
         end
         S_E: begin
            e_in     = e_ff - 32'(d3_ff) + 32'(prod_ff[33:23]);
            cnt_in   = '0;
            state_in = S_SQE1;
         end
         S_SQE1: begin
            mul_a    = e_ff;
            mul_b    = e_ff;
            state_in = S_SQE2;
         end
         S_SQE2: begin
            e_in = sq_round[62:31];
            if (cnt_ff == CW'(7)) begin
               state_in = S_DIV0;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_SQE1;
            end
         end
         S_DIV0: begin
            den_in   = 33'd2147483648 + 33'(e_ff);
            state_in = S_DIV;
            cnt_in   = '0;
            // The numerator is loaded on the first divide step below.
            rem_in   = '0;
            nq_in    = '0;
            total_in = total_ff;
         end
         S_DIV: begin
            if (cnt_ff == '0) begin
               // Quotient fits 17 bits, so the top of the numerator starts as remainder.
               rem_in = 33'(n_full[47:17]);
               nq_in  = n_full[16:0];
               cnt_in = cnt_ff + 1'b1;
            end else begin
               if (trial >= den_ff) begin
                  rem_in = trial - den_ff;
                  nq_in  = {nq_ff[15:0], 1'b1};
               end else begin
                  rem_in = trial;
                  nq_in  = {nq_ff[15:0], 1'b0};
               end
               if (cnt_ff == CW'(17)) begin
                  state_in = S_SIGOUT;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         S_SIGOUT: begin
            res_in   = raw_ff[31] ? 32'd65536 - 32'(nq_ff) : 32'(nq_ff);
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.score     = res_ff;
               rsp_data_in.saturated = sat_ff;
               lin_in                = '0;
               for (int i = 0; i < FACTORS; i++) begin
                  s_in[i] = '0;
                  q_in[i] = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         use_linear_ff <= 1'b1;
         lin_ff        <= '0;
         for (int i = 0; i < FACTORS; i++) begin
            s_ff[i] <= '0;
            q_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
         use_linear_ff <= use_linear_in;
         lin_ff        <= lin_in;
         s_ff          <= s_in;
         q_ff          <= q_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff     <= base_in;
      x_ff        <= x_in;
      last_ff     <= last_in;
      norm_ff     <= norm_in;
      p_ff        <= p_in;
      prod_ff     <= mul_prod;
      m_ff        <= m_in;
      sq_ff       <= sq_in;
      total_ff    <= total_in;
      raw_ff      <= raw_in;
      sat_ff      <= sat_in;
      res_ff      <= res_in;
      h_ff        <= h_in;
      h2_ff       <= h2_in;
      h3_ff       <= h3_in;
      h4_ff       <= h4_in;
      d3_ff       <= d3_in;
      e_ff        <= e_in;
      den_ff      <= den_in;
      rem_ff      <= rem_in;
      nq_ff       <= nq_in;
      rsp_data_ff <= rsp_data_in;
   end
endmodule
